FILE: rtl/wimde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wimde_pkg: shared types and constants
// Operation codes, sequencer states and fixed widths of the wide unit.
// ----------------------------------------------------------------------------
package wimde_pkg;

    localparam int OPERAND_BITS = 256;
    localparam int LIMB_BITS    = 64;
    localparam int DIGIT_BITS   = 32;
    localparam int NDIGITS      = OPERAND_BITS / DIGIT_BITS;
    localparam int DIGIT_IDX_W  = $clog2(NDIGITS);
    localparam int STEP_W       = $clog2(OPERAND_BITS);

    typedef logic [OPERAND_BITS-1:0] wide_t;

    typedef enum logic [2:0] {
        KIND_MUL   = 3'd0,
        KIND_UDIV  = 3'd1,
        KIND_UREM  = 3'd2,
        KIND_SDIV  = 3'd3,
        KIND_SREM  = 3'd4,
        KIND_POWER = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_PCHK,
        ST_PMUL,
        ST_PSQ,
        ST_EMIT
    } state_t;

endpackage

FILE: rtl/wimde_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wimde_mul: iterative low-half wide multiplier
// One 32x32 multiplier walks the digit pairs whose product lands in the low
// 256 bits; a registered product is shifted and added into the accumulator.
// ----------------------------------------------------------------------------
module wimde_mul
    import wimde_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  wide_t x,
    input  wide_t y,
    output logic  done,
    output wide_t p
);

    logic                   run_reg;
    logic [DIGIT_IDX_W-1:0] i_reg;
    logic [DIGIT_IDX_W-1:0] j_reg;
    logic                   pv_reg;
    logic                   plast_reg;
    logic [2*DIGIT_BITS-1:0] prod_reg;
    logic [DIGIT_IDX_W-1:0] sh_reg;
    wide_t                  acc_reg;
    logic                   done_reg;

    logic [DIGIT_BITS-1:0]   x_dig;
    logic [DIGIT_BITS-1:0]   y_dig;
    logic [2*DIGIT_BITS-1:0] prod_next;
    logic                    is_last;
    logic                    row_end;
    wide_t                   addend;

    assign x_dig     = x[i_reg*DIGIT_BITS +: DIGIT_BITS];
    assign y_dig     = y[j_reg*DIGIT_BITS +: DIGIT_BITS];
    assign prod_next = x_dig * y_dig;
    assign is_last   = (j_reg == DIGIT_IDX_W'(NDIGITS - 1));
    assign row_end   = (i_reg == (DIGIT_IDX_W'(NDIGITS - 1) - j_reg));
    assign addend    = wide_t'(prod_reg) << (sh_reg * DIGIT_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            pv_reg    <= 1'b0;
            plast_reg <= 1'b0;
            done_reg  <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            done_reg <= pv_reg && plast_reg;
            if (start)
            begin
                run_reg   <= 1'b1;
                pv_reg    <= 1'b0;
                plast_reg <= 1'b0;
                i_reg     <= '0;
                j_reg     <= '0;
            end
            else
            begin
                pv_reg    <= run_reg;
                plast_reg <= run_reg && is_last;
                if (run_reg)
                begin
                    if (is_last)
                    begin
                        run_reg <= 1'b0;
                    end
                    else if (row_end)
                    begin
                        i_reg <= '0;
                        j_reg <= j_reg + 1'b1;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sh_reg   <= i_reg + j_reg;
        if (start)
        begin
            acc_reg <= '0;
        end
        else if (pv_reg)
        begin
            acc_reg <= acc_reg + addend;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

FILE: rtl/wimde_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wimde_div: bit-serial unsigned divider
// Restoring shift-subtract, one quotient bit per cycle; zero divisor gives
// zero quotient and zero remainder.
// ----------------------------------------------------------------------------
module wimde_div
    import wimde_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  wide_t n,
    input  wide_t d,
    output logic  done,
    output wide_t q,
    output wide_t r
);

    logic              run_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    wide_t             nq_reg;
    wide_t             r_reg;
    wide_t             d_reg;

    wide_t             rs;
    logic [OPERAND_BITS:0] diff;
    logic              take;

    assign rs   = {r_reg[OPERAND_BITS-2:0], nq_reg[OPERAND_BITS-1]};
    assign diff = {r_reg[OPERAND_BITS-1], rs} - {1'b0, d_reg};
    assign take = !diff[OPERAND_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                run_reg  <= (d != '0);
                done_reg <= (d == '0);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(OPERAND_BITS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg <= (d == '0) ? '0 : n;
            r_reg  <= '0;
            d_reg  <= d;
        end
        else if (run_reg)
        begin
            nq_reg <= {nq_reg[OPERAND_BITS-2:0], take};
            r_reg  <= take ? diff[OPERAND_BITS-1:0] : rs;
        end
    end

    assign done = done_reg;
    assign q    = nq_reg;
    assign r    = r_reg;

endmodule

FILE: rtl/wide_int_mul_div_exp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wide_int_mul_div_exp_unit: 256-bit multiply, divide, remainder and power
// One item at a time. A multiply walks the 36 digit pairs on the shared
// 32x32 multiplier; divide and remainder run on the one-bit-per-cycle
// subtractor, which a zero divisor skips; power squares once per exponent
// bit up to the top set bit and multiplies only for the set bits.
// The result register frees the input side once loaded.
// ----------------------------------------------------------------------------
module wide_int_mul_div_exp_unit
    import wimde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [63:0] operand_a_0,
    input  logic [63:0] operand_a_1,
    input  logic [63:0] operand_a_2,
    input  logic [63:0] operand_a_3,
    input  logic [63:0] operand_b_0,
    input  logic [63:0] operand_b_1,
    input  logic [63:0] operand_b_2,
    input  logic [63:0] operand_b_3,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] result_0,
    output logic [63:0] result_1,
    output logic [63:0] result_2,
    output logic [63:0] result_3
);

    state_t state_reg, state_next;
    logic   out_valid_reg;
    logic [2:0] kind_reg;
    logic   an_reg, bn_reg;
    wide_t  a_reg, b_reg, res_reg, out_reg;

    wide_t  a_in, b_in, a_abs, b_abs, x_sel, y_sel, p, q, r;
    wide_t  div_sel, div_res;
    logic   accept, emit, signed_in, an_in, bn_in, div_neg;
    logic   mul_start, mul_done, div_start, div_done;

    assign a_in = {operand_a_3, operand_a_2, operand_a_1, operand_a_0};
    assign b_in = {operand_b_3, operand_b_2, operand_b_1, operand_b_0};
    assign accept = in_valid && !in_stall;
    assign signed_in = (kind == KIND_SDIV) || (kind == KIND_SREM);
    assign an_in = signed_in && a_in[OPERAND_BITS-1];
    assign bn_in = signed_in && b_in[OPERAND_BITS-1];
    assign a_abs = an_in ? (wide_t'(0) - a_in) : a_in;
    assign b_abs = bn_in ? (wide_t'(0) - b_in) : b_in;
    assign emit  = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    wimde_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (x_sel),
        .y     (y_sel),
        .done  (mul_done),
        .p     (p)
    );

    wimde_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (a_abs),
        .d     (b_abs),
        .done  (div_done),
        .q     (q),
        .r     (r)
    );

    always_comb
    begin
        case (kind_reg)
            KIND_UDIV: begin div_sel = q; div_neg = 1'b0; end
            KIND_UREM: begin div_sel = r; div_neg = 1'b0; end
            KIND_SDIV: begin div_sel = q; div_neg = an_reg ^ bn_reg; end
            default:   begin div_sel = r; div_neg = an_reg; end
        endcase
    end

    assign div_res = div_neg ? (wide_t'(0) - div_sel) : div_sel;

    always_comb
    begin
        case (state_reg)
            ST_PMUL:
            begin
                x_sel = res_reg;
                y_sel = a_reg;
            end
            ST_PSQ:
            begin
                x_sel = a_reg;
                y_sel = a_reg;
            end
            default:
            begin
                x_sel = a_reg;
                y_sel = b_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_MUL:   state_next = ST_MUL;
                        KIND_UDIV, KIND_UREM, KIND_SDIV, KIND_SREM:
                                    state_next = ST_DIV;
                        KIND_POWER: state_next = ST_PCHK;
                        default:    state_next = ST_EMIT;
                    endcase
                end
            end
            ST_MUL:  if (mul_done) state_next = ST_EMIT;
            ST_DIV:  if (div_done) state_next = ST_EMIT;
            ST_PCHK:
            begin
                if (b_reg == '0)
                    state_next = ST_EMIT;
                else if (b_reg[0])
                    state_next = ST_PMUL;
                else
                    state_next = ST_PSQ;
            end
            ST_PMUL: if (mul_done) state_next = ST_PSQ;
            ST_PSQ:  if (mul_done) state_next = ST_PCHK;
            ST_EMIT: if (emit) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        mul_start = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                mul_start = in_valid && (kind == KIND_MUL);
                div_start = in_valid && ((kind == KIND_UDIV) || (kind == KIND_UREM)
                            || (kind == KIND_SDIV) || (kind == KIND_SREM));
            end
            ST_PCHK: mul_start = (b_reg != '0);
            ST_PMUL: mul_start = mul_done;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            an_reg   <= an_in;
            bn_reg   <= bn_in;
            a_reg    <= a_in;
            b_reg    <= b_in;
            res_reg  <= (kind == KIND_POWER) ? wide_t'(1) : '0;
        end
        else
        begin
            case (state_reg)
                ST_MUL:  if (mul_done) res_reg <= p;
                ST_DIV:  if (div_done) res_reg <= div_res;
                ST_PMUL: if (mul_done) res_reg <= p;
                ST_PSQ:
                begin
                    if (mul_done)
                    begin
                        a_reg <= p;
                        b_reg <= b_reg >> 1;
                    end
                end
                default: ;
            endcase
        end
        if (emit)
            out_reg <= res_reg;
    end

    assign out_valid = out_valid_reg;
    assign result_0  = out_reg[0*LIMB_BITS +: LIMB_BITS];
    assign result_1  = out_reg[1*LIMB_BITS +: LIMB_BITS];
    assign result_2  = out_reg[2*LIMB_BITS +: LIMB_BITS];
    assign result_3  = out_reg[3*LIMB_BITS +: LIMB_BITS];

endmodule

FILE: dv/wide_int_mul_div_exp_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wide_int_mul_div_exp_unit_test: self-checking bench for the 256-bit unit
// Drives directed corner operands, then random multiply, divide, remainder
// and power transfers with random idle and stall on both sides. Each result
// is compared limb by limb against a local arithmetic model of the unit.
// ----------------------------------------------------------------------------
module wide_int_mul_div_exp_unit_test;
    import wimde_pkg::*;

    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;
    localparam int         RANDOM_ITEMS = 1400;
    localparam int         CYCLE_LIMIT  = 6000000;
    localparam int         HOLD_CYCLES  = 3000;

    class wide_result_board;
        wide_t result_q[$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        function wide_t raise(wide_t base, wide_t expo);
            wide_t acc;
            wide_t sq;
            acc = 1;
            sq  = base;
            for (int i = 0; i < OPERAND_BITS; i++)
            begin
                if (expo[i])
                    acc = acc * sq;
                sq = sq * sq;
            end
            return acc;
        endfunction

        function void note_input(logic [2:0] op, wide_t a, wide_t b);
            wide_t r;
            wide_t am;
            wide_t bm;
            r  = '0;
            am = a[OPERAND_BITS-1] ? -a : a;
            bm = b[OPERAND_BITS-1] ? -b : b;
            case (op)
                KIND_MUL:   r = a * b;
                KIND_UDIV:  r = (b == 0) ? '0 : a / b;
                KIND_UREM:  r = (b == 0) ? '0 : a % b;
                KIND_SDIV:
                begin
                    if (b != 0)
                    begin
                        r = am / bm;
                        if (a[OPERAND_BITS-1] != b[OPERAND_BITS-1])
                            r = -r;
                    end
                end
                KIND_SREM:
                begin
                    if (b != 0)
                    begin
                        r = am % bm;
                        if (a[OPERAND_BITS-1])
                            r = -r;
                    end
                end
                KIND_POWER: r = raise(a, b);
                default:    r = '0;
            endcase
            result_q.push_back(r);
        endfunction

        function void check_result(wide_t got);
            wide_t want;
            if (result_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = result_q.pop_front();
            for (int i = 0; i < 4; i++)
                if (want[i*LIMB_BITS +: LIMB_BITS] != got[i*LIMB_BITS +: LIMB_BITS])
                begin
                    $display("%0t: result_%0d expected %h actual %h", $time, i,
                             want[i*LIMB_BITS +: LIMB_BITS], got[i*LIMB_BITS +: LIMB_BITS]);
                    errors++;
                end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  kind;
    logic [63:0] operand_a_0, operand_a_1, operand_a_2, operand_a_3;
    logic [63:0] operand_b_0, operand_b_1, operand_b_2, operand_b_3;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] result_0, result_1, result_2, result_3;

    wide_result_board board;
    bit               quiet;
    bit               hold_req;
    int               hold_left = 0;
    int               cycles = 0;

    wide_int_mul_div_exp_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
        .operand_a_0(operand_a_0), .operand_a_1(operand_a_1),
        .operand_a_2(operand_a_2), .operand_a_3(operand_a_3),
        .operand_b_0(operand_b_0), .operand_b_1(operand_b_1),
        .operand_b_2(operand_b_2), .operand_b_3(operand_b_3),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_0(result_0), .result_1(result_1),
        .result_2(result_2), .result_3(result_3)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("wide_int_mul_div_exp_unit_test NOT OK");
            $finish;
        end
    end

    // hold off the result side for a long stretch when asked
    always @(posedge clk)
    begin
        if (hold_req && hold_left == 0)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_result({result_3, result_2, result_1, result_0});
            if (hold_left > 1 || (hold_req && hold_left == 0))
                out_stall <= 1'b1;
            else
                out_stall <= !quiet && ($urandom_range(99) < 20);
        end
    end

    function automatic wide_t random_wide();
        wide_t w;
        for (int i = 0; i < 8; i++)
            w[i*32 +: 32] = $urandom;
        return w;
    endfunction

    function automatic wide_t shaped_wide();
        wide_t w;
        w = random_wide();
        case ($urandom_range(9))
            0: w = '0;
            1: w = '1;
            2: w = {1'b1, {(OPERAND_BITS-1){1'b0}}};
            3: w = wide_t'(1) << $urandom_range(OPERAND_BITS-1);
            4: w = w >> $urandom_range(OPERAND_BITS-1);
            5: w = -(w >> $urandom_range(OPERAND_BITS-1));
            6: w = wide_t'($urandom_range(5)) - 2;
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_item(logic [2:0] op, wide_t a, wide_t b);
        in_valid    <= 1'b1;
        kind        <= op;
        operand_a_0 <= a[63:0];
        operand_a_1 <= a[127:64];
        operand_a_2 <= a[191:128];
        operand_a_3 <= a[255:192];
        operand_b_0 <= b[63:0];
        operand_b_1 <= b[127:64];
        operand_b_2 <= b[191:128];
        operand_b_3 <= b[255:192];
        do
            @(posedge clk);
        while (in_stall);
        board.note_input(op, a, b);
    endtask

    task automatic idle_gap();
        if (!quiet && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.result_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        wide_t      a;
        wide_t      b;
        wide_t      minv;
        logic [2:0] op;
        board       = new();
        minv        = {1'b1, {(OPERAND_BITS-1){1'b0}}};
        quiet       = 1'b0;
        hold_req    = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = KIND_MUL;
        operand_a_0 = '0;
        operand_a_1 = '0;
        operand_a_2 = '0;
        operand_a_3 = '0;
        operand_b_0 = '0;
        operand_b_1 = '0;
        operand_b_2 = '0;
        operand_b_3 = '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(KIND_MUL, '1, '1);
        send_item(KIND_MUL, '0, '1);
        send_item(KIND_MUL, random_wide(), random_wide());
        send_item(KIND_UDIV, random_wide(), '0);
        send_item(KIND_UREM, random_wide(), '0);
        send_item(KIND_SDIV, random_wide(), '0);
        send_item(KIND_SREM, random_wide(), '0);
        send_item(KIND_SDIV, minv, '1);
        send_item(KIND_SREM, minv, '1);
        send_item(KIND_SDIV, -wide_t'(7), wide_t'(2));
        send_item(KIND_SREM, -wide_t'(7), wide_t'(2));
        send_item(KIND_SDIV, wide_t'(7), -wide_t'(2));
        send_item(KIND_SREM, wide_t'(7), -wide_t'(2));
        send_item(KIND_UDIV, '1, wide_t'(1));
        send_item(KIND_UREM, '1, wide_t'(3));
        send_item(KIND_UDIV, random_wide(), '1);
        send_item(KIND_SPARE_6, random_wide(), random_wide());
        send_item(KIND_SPARE_7, random_wide(), random_wide());
        send_item(KIND_POWER, '0, '0);
        send_item(KIND_POWER, wide_t'(5), '0);
        send_item(KIND_POWER, wide_t'(2), wide_t'(255));
        send_item(KIND_POWER, wide_t'(3), '1);
        send_item(KIND_POWER, random_wide(), wide_t'(65537));
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet    = (n >= 300 && n < 500);
            hold_req = (n == 700);
            if (n == 900)
                drain();
            case ($urandom_range(13))
                0, 1:       op = KIND_MUL;
                2, 3:       op = KIND_UDIV;
                4, 5:       op = KIND_UREM;
                6, 7:       op = KIND_SDIV;
                8, 9:       op = KIND_SREM;
                10, 11, 12: op = KIND_POWER;
                default:    op = $urandom_range(1) ? KIND_SPARE_6 : KIND_SPARE_7;
            endcase
            a = shaped_wide();
            b = shaped_wide();
            if (op == KIND_POWER)
            begin
                if ($urandom_range(199) == 0)
                    b = random_wide();
                else if ($urandom_range(9) == 0)
                    b = wide_t'($urandom);
                else
                    b = wide_t'($urandom_range(255));
            end
            idle_gap();
            send_item(op, a, b);
        end
        hold_req = 1'b0;
        drain();
        repeat (50)
            @(posedge clk);
        if (board.errors == 0 && board.result_q.size() == 0)
            $display("wide_int_mul_div_exp_unit_test OK");
        else
            $display("wide_int_mul_div_exp_unit_test NOT OK");
        $finish;
    end

endmodule
